/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Subleq core
// Implication checks clocked on the core clock, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define SBQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("subleq core check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define SBQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("subleq core check failed");

`endif

/* design/sbq_pkg.sv */
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package sbq_pkg;

	localparam int MEM_DEPTH_DEF = 1024;
	localparam int WORD_BITS_DEF = 32;

	localparam int CFG_BITS = 11;
	localparam logic [CFG_BITS-1:0] CFG_RESET_WORDS = 11'd1024;

	// Item commands.
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;
	localparam logic [1:0] CMD_STEP    = 2'd3;

	// Halt status codes.
	localparam logic [2:0] STAT_RUNNING    = 3'd0;
	localparam logic [2:0] STAT_PC_RANGE   = 3'd1;
	localparam logic [2:0] STAT_INCOMPLETE = 3'd2;
	localparam logic [2:0] STAT_OUT_SRC    = 3'd3;
	localparam logic [2:0] STAT_IN_DST     = 3'd4;
	localparam logic [2:0] STAT_BAD_A      = 3'd5;
	localparam logic [2:0] STAT_BAD_B      = 3'd6;

	localparam logic [31:0] PC_STEP = 32'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_READ_CAP,
		S_FETCH_B,
		S_FETCH_C,
		S_EXEC,
		S_OUT_CAP,
		S_SUB_B,
		S_SUB_W,
		S_FINISH
	} state_t;

	// Memory address source.
	typedef enum logic [2:0] {
		ASEL_CLEAR,
		ASEL_WORD,
		ASEL_PC0,
		ASEL_PC1,
		ASEL_PC2,
		ASEL_A,
		ASEL_B
	} asel_t;

	// Memory write data source.
	typedef enum logic [1:0] {
		WSEL_ZERO,
		WSEL_WRITE,
		WSEL_CONSOLE,
		WSEL_DIFF
	} wsel_t;

	typedef enum logic [1:0] {
		PC_HOLD,
		PC_ZERO,
		PC_PLUS3,
		PC_SUBLEQ
	} pcsel_t;

	typedef enum logic [1:0] {
		HALT_KEEP,
		HALT_CLEAR,
		HALT_SET
	} halt_act_t;

	typedef struct packed {
		logic      load_item;
		logic      clear_res;
		logic      clr_step;
		logic      mem_we;
		asel_t     asel;
		wsel_t     wsel;
		logic      cap_a;
		logic      cap_b;
		logic      cap_c;
		logic      cap_opa;
		logic      cap_read;
		logic      cap_out;
		logic      set_in_taken;
		pcsel_t    pc_sel;
		halt_act_t halt_act;
		logic [2:0] halt_code;
		logic      load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       halted;
		logic       pc_bad;
		logic       pc_short;
		logic       waddr_ok;
		logic       is_out;
		logic       is_in;
		logic       a_ok;
		logic       b_ok;
		logic       clr_last;
	} dp_status_t;

endpackage

`default_nettype wire

/* design/sbq_ctrl.sv */
// ----------------------------------------------------------------------------
// sbq_ctrl
// Sequencer for the Subleq core: clearing pass, command decode, fetch and
// execute steps, and the output beat handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module sbq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	input  wire sbq_pkg::dp_status_t stat,
	output sbq_pkg::ctrl_cmd_t      cmd
);

	sbq_pkg::state_t state_q;
	sbq_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != sbq_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbq_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sbq_pkg::S_CLEAR: begin
				if (stat.clr_last) state_d = sbq_pkg::S_IDLE;
			end
			sbq_pkg::S_IDLE: begin
				if (in_valid) state_d = sbq_pkg::S_DECODE;
			end
			sbq_pkg::S_DECODE: begin
				case (stat.cmd)
					sbq_pkg::CMD_READ: state_d = sbq_pkg::S_READ_CAP;
					sbq_pkg::CMD_STEP: begin
						if (!stat.halted && !stat.pc_bad && !stat.pc_short) begin
							state_d = sbq_pkg::S_FETCH_B;
						end else begin
							state_d = sbq_pkg::S_FINISH;
						end
					end
					default: state_d = sbq_pkg::S_FINISH;
				endcase
			end
			sbq_pkg::S_READ_CAP: state_d = sbq_pkg::S_FINISH;
			sbq_pkg::S_FETCH_B:  state_d = sbq_pkg::S_FETCH_C;
			sbq_pkg::S_FETCH_C:  state_d = sbq_pkg::S_EXEC;
			sbq_pkg::S_EXEC: begin
				if (stat.is_out) begin
					state_d = stat.b_ok ? sbq_pkg::S_OUT_CAP : sbq_pkg::S_FINISH;
				end else if (stat.is_in) begin
					state_d = sbq_pkg::S_FINISH;
				end else if (stat.a_ok && stat.b_ok) begin
					state_d = sbq_pkg::S_SUB_B;
				end else begin
					state_d = sbq_pkg::S_FINISH;
				end
			end
			sbq_pkg::S_OUT_CAP: state_d = sbq_pkg::S_FINISH;
			sbq_pkg::S_SUB_B:   state_d = sbq_pkg::S_SUB_W;
			sbq_pkg::S_SUB_W:   state_d = sbq_pkg::S_FINISH;
			sbq_pkg::S_FINISH: begin
				if (out_free) state_d = sbq_pkg::S_IDLE;
			end
			default: state_d = sbq_pkg::S_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd.load_item    = 1'b0;
		cmd.clear_res    = 1'b0;
		cmd.clr_step     = 1'b0;
		cmd.mem_we       = 1'b0;
		cmd.asel         = sbq_pkg::ASEL_WORD;
		cmd.wsel         = sbq_pkg::WSEL_ZERO;
		cmd.cap_a        = 1'b0;
		cmd.cap_b        = 1'b0;
		cmd.cap_c        = 1'b0;
		cmd.cap_opa      = 1'b0;
		cmd.cap_read     = 1'b0;
		cmd.cap_out      = 1'b0;
		cmd.set_in_taken = 1'b0;
		cmd.pc_sel       = sbq_pkg::PC_HOLD;
		cmd.halt_act     = sbq_pkg::HALT_KEEP;
		cmd.halt_code    = sbq_pkg::STAT_RUNNING;
		cmd.load_out     = 1'b0;
		case (state_q)
			sbq_pkg::S_CLEAR: begin
				cmd.mem_we   = 1'b1;
				cmd.asel     = sbq_pkg::ASEL_CLEAR;
				cmd.clr_step = 1'b1;
			end
			sbq_pkg::S_IDLE: begin
				cmd.load_item = in_valid;
			end
			sbq_pkg::S_DECODE: begin
				cmd.clear_res = 1'b1;
				case (stat.cmd)
					sbq_pkg::CMD_WRITE: begin
						cmd.mem_we = stat.waddr_ok;
						cmd.wsel   = sbq_pkg::WSEL_WRITE;
					end
					sbq_pkg::CMD_RESTART: begin
						cmd.pc_sel   = sbq_pkg::PC_ZERO;
						cmd.halt_act = sbq_pkg::HALT_CLEAR;
					end
					sbq_pkg::CMD_STEP: begin
						cmd.asel = sbq_pkg::ASEL_PC0;
						if (!stat.halted) begin
							if (stat.pc_bad) begin
								cmd.halt_act  = sbq_pkg::HALT_SET;
								cmd.halt_code = sbq_pkg::STAT_PC_RANGE;
							end else if (stat.pc_short) begin
								cmd.halt_act  = sbq_pkg::HALT_SET;
								cmd.halt_code = sbq_pkg::STAT_INCOMPLETE;
							end
						end
					end
					default: begin
						cmd.asel = sbq_pkg::ASEL_WORD;
					end
				endcase
			end
			sbq_pkg::S_READ_CAP: cmd.cap_read = 1'b1;
			sbq_pkg::S_FETCH_B: begin
				cmd.cap_a = 1'b1;
				cmd.asel  = sbq_pkg::ASEL_PC1;
			end
			sbq_pkg::S_FETCH_C: begin
				cmd.cap_b = 1'b1;
				cmd.asel  = sbq_pkg::ASEL_PC2;
			end
			sbq_pkg::S_EXEC: begin
				cmd.cap_c = 1'b1;
				if (stat.is_out) begin
					cmd.asel = sbq_pkg::ASEL_B;
					if (!stat.b_ok) begin
						cmd.halt_act  = sbq_pkg::HALT_SET;
						cmd.halt_code = sbq_pkg::STAT_OUT_SRC;
					end
				end else if (stat.is_in) begin
					cmd.asel = sbq_pkg::ASEL_A;
					if (!stat.a_ok) begin
						cmd.halt_act  = sbq_pkg::HALT_SET;
						cmd.halt_code = sbq_pkg::STAT_IN_DST;
					end else begin
						cmd.mem_we       = 1'b1;
						cmd.wsel         = sbq_pkg::WSEL_CONSOLE;
						cmd.set_in_taken = 1'b1;
						cmd.pc_sel       = sbq_pkg::PC_PLUS3;
					end
				end else begin
					cmd.asel = sbq_pkg::ASEL_A;
					if (!stat.a_ok) begin
						cmd.halt_act  = sbq_pkg::HALT_SET;
						cmd.halt_code = sbq_pkg::STAT_BAD_A;
					end else if (!stat.b_ok) begin
						cmd.halt_act  = sbq_pkg::HALT_SET;
						cmd.halt_code = sbq_pkg::STAT_BAD_B;
					end
				end
			end
			sbq_pkg::S_OUT_CAP: begin
				cmd.cap_out = 1'b1;
				cmd.pc_sel  = sbq_pkg::PC_PLUS3;
			end
			sbq_pkg::S_SUB_B: begin
				cmd.cap_opa = 1'b1;
				cmd.asel    = sbq_pkg::ASEL_B;
			end
			sbq_pkg::S_SUB_W: begin
				cmd.mem_we = 1'b1;
				cmd.asel   = sbq_pkg::ASEL_A;
				cmd.wsel   = sbq_pkg::WSEL_DIFF;
				cmd.pc_sel = sbq_pkg::PC_SUBLEQ;
			end
			sbq_pkg::S_FINISH: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd.load_out = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/sbq_dp.sv */
// ----------------------------------------------------------------------------
// sbq_dp
// Datapath of the Subleq core: word memory, program counter, halt state,
// operand registers, subtractor and the output beat registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sbq_dp #(
	parameter int MEM_DEPTH = sbq_pkg::MEM_DEPTH_DEF,
	parameter int WORD_BITS = sbq_pkg::WORD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sbq_pkg::ctrl_cmd_t             cmd,
	output sbq_pkg::dp_status_t                 stat,
	input  wire logic                           cfg_we,
	input  wire logic [sbq_pkg::CFG_BITS-1:0]   cfg_data,
	input  wire logic [1:0]                     command,
	input  wire logic [9:0]                     word_address,
	input  wire logic signed [31:0]             write_value,
	input  wire logic signed [31:0]             console_input,
	output logic signed [31:0]                  read_value,
	output logic                                output_valid,
	output logic signed [31:0]                  output_value,
	output logic                                input_taken,
	output logic                                halted,
	output logic [2:0]                          status,
	output logic signed [31:0]                  next_pc
);

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int XW = ((WORD_BITS > 32) ? WORD_BITS : 32) + 1;
	localparam logic [WORD_BITS-1:0] NEG_ONE = '1;
	localparam logic [WORD_BITS-1:0] NEG_TWO = ~(WORD_BITS'(1));

	logic [WORD_BITS-1:0] mem_q [MEM_DEPTH];
	logic [WORD_BITS-1:0] rdata_q;
	logic [AW-1:0]        mem_addr;
	logic [XW-1:0]        addr_x;
	logic [WORD_BITS-1:0] wdata;

	logic [1:0]           cmd_q;
	logic [9:0]           waddr_q;
	logic [31:0]          wval_q;
	logic [31:0]          cin_q;

	logic [31:0]          pc_q;
	logic                 halted_q;
	logic [2:0]           reason_q;
	logic [sbq_pkg::CFG_BITS-1:0] cfg_q;
	logic [AW-1:0]        clr_q;

	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] c_q;
	logic [WORD_BITS-1:0] opa_q;
	logic [WORD_BITS-1:0] diff;
	logic                 diff_leq;

	logic [31:0]          res_read_q;
	logic                 res_out_valid_q;
	logic [31:0]          res_out_value_q;
	logic                 res_in_taken_q;

	logic [31:0]          read_value_q;
	logic                 output_valid_q;
	logic [31:0]          output_value_q;
	logic                 input_taken_q;
	logic                 halted_out_q;
	logic [2:0]           status_q;
	logic [31:0]          next_pc_q;

	logic [XW-1:0]        size_x;
	logic [XW-1:0]        pc_x;
	logic [XW-1:0]        a_x;
	logic [XW-1:0]        b_x;
	logic [XW-1:0]        waddr_x;
	logic [31:0]          pc_plus3;

	// Words in use, limited to the physical depth.
	assign size_x  = (XW'(cfg_q) < XW'(MEM_DEPTH)) ? XW'(cfg_q) : XW'(MEM_DEPTH);
	assign pc_x    = XW'(pc_q);
	assign a_x     = XW'(a_q);
	assign b_x     = XW'(b_q);
	assign waddr_x = XW'(waddr_q);
	assign pc_plus3 = pc_q + sbq_pkg::PC_STEP;

	assign stat.cmd      = cmd_q;
	assign stat.halted   = halted_q;
	assign stat.pc_bad   = pc_q[31] || (pc_x >= size_x);
	assign stat.pc_short = (pc_x + XW'(2)) >= size_x;
	assign stat.waddr_ok = waddr_x < XW'(MEM_DEPTH);
	assign stat.is_out   = (a_q == NEG_TWO);
	assign stat.is_in    = (b_q == NEG_ONE);
	assign stat.a_ok     = !a_q[WORD_BITS-1] && (a_x < size_x);
	assign stat.b_ok     = !b_q[WORD_BITS-1] && (b_x < size_x);
	assign stat.clr_last = (clr_q == AW'(MEM_DEPTH - 1));

	assign diff     = opa_q - rdata_q;
	assign diff_leq = (diff == '0) || diff[WORD_BITS-1];

	always_comb begin
		case (cmd.asel)
			sbq_pkg::ASEL_CLEAR: addr_x = XW'(clr_q);
			sbq_pkg::ASEL_WORD:  addr_x = waddr_x;
			sbq_pkg::ASEL_PC0:   addr_x = pc_x;
			sbq_pkg::ASEL_PC1:   addr_x = pc_x + XW'(1);
			sbq_pkg::ASEL_PC2:   addr_x = pc_x + XW'(2);
			sbq_pkg::ASEL_A:     addr_x = a_x;
			sbq_pkg::ASEL_B:     addr_x = b_x;
			default:             addr_x = '0;
		endcase
	end

	assign mem_addr = addr_x[AW-1:0];

	always_comb begin
		case (cmd.wsel)
			sbq_pkg::WSEL_ZERO:    wdata = '0;
			sbq_pkg::WSEL_WRITE:   wdata = WORD_BITS'($signed(wval_q));
			sbq_pkg::WSEL_CONSOLE: wdata = WORD_BITS'($signed(cin_q));
			sbq_pkg::WSEL_DIFF:    wdata = diff;
			default:               wdata = '0;
		endcase
	end

	// Single-port word memory with registered read data.
	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem_q[mem_addr] <= wdata;
		end
		rdata_q <= mem_q[mem_addr];
	end

	// Item and operand registers.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q   <= command;
			waddr_q <= word_address;
			wval_q  <= write_value;
			cin_q   <= console_input;
		end
		if (cmd.cap_a)   a_q   <= rdata_q;
		if (cmd.cap_b)   b_q   <= rdata_q;
		if (cmd.cap_c)   c_q   <= rdata_q;
		if (cmd.cap_opa) opa_q <= rdata_q;

		if (cmd.clear_res) begin
			res_read_q      <= '0;
			res_out_valid_q <= 1'b0;
			res_out_value_q <= '0;
			res_in_taken_q  <= 1'b0;
		end else begin
			if (cmd.cap_read) begin
				res_read_q <= stat.waddr_ok ? 32'($signed(rdata_q)) : 32'd0;
			end
			if (cmd.cap_out) begin
				res_out_valid_q <= 1'b1;
				res_out_value_q <= 32'($signed(rdata_q));
			end
			if (cmd.set_in_taken) res_in_taken_q <= 1'b1;
		end

		if (cmd.load_out) begin
			read_value_q   <= res_read_q;
			output_valid_q <= res_out_valid_q;
			output_value_q <= res_out_value_q;
			input_taken_q  <= res_in_taken_q;
			halted_out_q   <= halted_q;
			status_q       <= reason_q;
			next_pc_q      <= pc_q;
		end
	end

	// Architectural state, clearing counter and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			halted_q <= 1'b0;
			reason_q <= sbq_pkg::STAT_RUNNING;
			cfg_q    <= sbq_pkg::CFG_RESET_WORDS;
			clr_q    <= '0;
		end else begin
			if (cfg_we) cfg_q <= cfg_data;
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);

			case (cmd.pc_sel)
				sbq_pkg::PC_ZERO:   pc_q <= '0;
				sbq_pkg::PC_PLUS3:  pc_q <= pc_plus3;
				sbq_pkg::PC_SUBLEQ: pc_q <= diff_leq ? 32'($signed(c_q)) : pc_plus3;
				default:            pc_q <= pc_q;
			endcase

			case (cmd.halt_act)
				sbq_pkg::HALT_CLEAR: begin
					halted_q <= 1'b0;
					reason_q <= sbq_pkg::STAT_RUNNING;
				end
				sbq_pkg::HALT_SET: begin
					halted_q <= 1'b1;
					reason_q <= cmd.halt_code;
				end
				default: begin
					halted_q <= halted_q;
				end
			endcase
		end
	end

	assign read_value   = read_value_q;
	assign output_valid = output_valid_q;
	assign output_value = output_value_q;
	assign input_taken  = input_taken_q;
	assign halted       = halted_out_q;
	assign status       = status_q;
	assign next_pc      = next_pc_q;

endmodule

`default_nettype wire

/* design/subleq_one_instruction_cpu_core.sv */
// ----------------------------------------------------------------------------
// subleq_one_instruction_cpu_core
// Subleq one-instruction processor with a single-port word memory.
// ----------------------------------------------------------------------------
// Each input beat carries one command: write a memory word, read a memory
// word, restart at pc 0 with the halt cleared, or step one instruction, and
// each command returns exactly one output beat carrying the read word, the
// console output or input flags, and the halt flag, halt status and program
// counter after the command. Because every access goes through a single
// memory port with registered read data, a subleq step passes through
// fetch of A, B and C, reads of M[A] and M[B], write-back, and the output
// load before the next command can be accepted; the other commands take a
// shorter path through these steps. After reset the core sweeps zeros
// through all MEM_DEPTH words of the memory and holds in_stall high
// during that sweep; configuration writes are taken at any time, and the
// word count should only be changed while no command is in flight. The
// output beat sits in its own register, so a new command is accepted while
// a finished result still waits on out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module subleq_one_instruction_cpu_core #(
	parameter int MEM_DEPTH = sbq_pkg::MEM_DEPTH_DEF,
	parameter int WORD_BITS = sbq_pkg::WORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	// Configuration write channel: words in use.
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [sbq_pkg::CFG_BITS-1:0] memory_words_used,

	// Command channel.
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   command,
	input  wire logic [9:0]                   word_address,
	input  wire logic signed [31:0]           write_value,
	input  wire logic signed [31:0]           console_input,

	// Result channel.
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [31:0]                read_value,
	output logic                              output_valid,
	output logic signed [31:0]                output_value,
	output logic                              input_taken,
	output logic                              halted,
	output logic [2:0]                        status,
	output logic signed [31:0]                next_pc
);

	sbq_pkg::ctrl_cmd_t  ctrl_cmd;
	sbq_pkg::dp_status_t dp_stat;

	// The register is a plain flop, so every configuration beat is taken.
	assign cfg_ready = 1'b1;

	sbq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (dp_stat),
		.cmd       (ctrl_cmd)
	);

	sbq_dp #(
		.MEM_DEPTH (MEM_DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctrl_cmd),
		.stat          (dp_stat),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (memory_words_used),
		.command       (command),
		.word_address  (word_address),
		.write_value   (write_value),
		.console_input (console_input),
		.read_value    (read_value),
		.output_valid  (output_valid),
		.output_value  (output_value),
		.input_taken   (input_taken),
		.halted        (halted),
		.status        (status),
		.next_pc       (next_pc)
	);

endmodule

`default_nettype wire

/* design/sbq_checker.sv */
// ----------------------------------------------------------------------------
// sbq_checker
// Port-level checks on the Subleq core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sbq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        output_valid,
	input wire logic        input_taken,
	input wire logic        halted,
	input wire logic [2:0]  status
);

	// An accepted command takes the core out of idle, so the core is busy right after acceptance.
	`SBQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// One step is either an output or an input instruction, never both.
	`SBQ_ASSERT_NOW(a_out_in_exclusive, clk, arst_n, out_valid, !(output_valid && input_taken))

	// The status is nonzero exactly when the core reports itself halted.
	`SBQ_ASSERT_NOW(a_halt_status, clk, arst_n, out_valid,
		halted == (status != sbq_pkg::STAT_RUNNING))

	// A stalled result beat stays offered.
	`SBQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

endmodule

bind subleq_one_instruction_cpu_core sbq_checker u_sbq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.output_valid (output_valid),
	.input_taken  (input_taken),
	.halted       (halted),
	.status       (status)
);

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for subleq_one_instruction_cpu_core
// Drives command beats through the valid/stall input channel, predicts every
// result beat with its own model of the Subleq core or takes it from the
// directed table, and compares each accepted result field by field. Both
// channels idle and stall at random. A directed opening walks a stimulus
// table; it is followed by randomly built programs that are loaded,
// restarted and single-stepped under several word counts.
// ----------------------------------------------------------------------------

module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MEM_DEPTH       = sbq_pkg::MEM_DEPTH_DEF;
	localparam int RESET_CYCLES    = 11;
	localparam int PHASES          = 8;
	localparam int BEATS_PER_PHASE = 175;
	localparam int LONG_HOLD       = 150;
	localparam int DRAIN_CYCLES    = 16;
	localparam int CYCLE_LIMIT     = 300000;

	// Operand patterns that select the output and input forms of an instruction.
	localparam logic [31:0] OPA_OUTPUT = 32'hFFFF_FFFE;
	localparam logic [31:0] OPB_INPUT  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [9:0]  addr;
		logic [31:0] wval;
		logic [31:0] cin;
	} cpu_beat_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        output_valid;
		logic [31:0] output_value;
		logic        input_taken;
		logic        halted;
		logic [2:0]  status;
		logic [31:0] next_pc;
	} cpu_result_t;

	typedef struct packed {
		cpu_beat_t   beat;
		logic        typed;
		cpu_result_t want;
	} directed_row_t;

	// Results that can be read straight off the command in the directed table.
	localparam cpu_result_t QUIET = '0;
	localparam cpu_result_t READ_MOST_NEG =
		'{32'h8000_0000, 1'b0, 32'd0, 1'b0, 1'b0, sbq_pkg::STAT_RUNNING, 32'd0};
	localparam cpu_result_t READ_MOST_POS =
		'{32'h7FFF_FFFF, 1'b0, 32'd0, 1'b0, 1'b0, sbq_pkg::STAT_RUNNING, 32'd0};
	localparam cpu_result_t HALT_PC_NEG =
		'{32'd0, 1'b0, 32'd0, 1'b0, 1'b1, sbq_pkg::STAT_PC_RANGE, 32'hFFFF_FFFB};
	localparam cpu_result_t HALT_OUT_SRC =
		'{32'd0, 1'b0, 32'd0, 1'b0, 1'b1, sbq_pkg::STAT_OUT_SRC, 32'd0};

	localparam int DIRECTED_ROWS = 24;

	// The opening table. It first touches the memory extremes after reset, then
	// builds a three-instruction program at address 0: an output of M[10], an
	// input into M[11], and a subtract whose negative result jumps to pc -5.
	// The next step halts on the negative pc, a further step shows the halted
	// core doing nothing, and a restart clears the halt. Finally the output
	// instruction gets a source address beyond the memory and halts on it.
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{'{sbq_pkg::CMD_READ,    10'd0,    32'd0,         32'd0},         1'b1, QUIET},
		'{'{sbq_pkg::CMD_READ,    10'd1023, 32'd0,         32'd0},         1'b1, QUIET},
		'{'{sbq_pkg::CMD_WRITE,   10'd1023, 32'h8000_0000, 32'd0},         1'b1, QUIET},
		'{'{sbq_pkg::CMD_READ,    10'd1023, 32'd0,         32'd0},         1'b1,
			READ_MOST_NEG},
		'{'{sbq_pkg::CMD_WRITE,   10'd0,    32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b1, QUIET},
		'{'{sbq_pkg::CMD_READ,    10'd0,    32'd0,         32'd0},         1'b1,
			READ_MOST_POS},
		'{'{sbq_pkg::CMD_WRITE,   10'd0,    OPA_OUTPUT,    32'd0},         1'b0, QUIET},
		'{'{sbq_pkg::CMD_WRITE,   10'd1,    32'd10,        32'd0},         1'b0, QUIET},
		'{'{sbq_pkg::CMD_WRITE,   10'd2,    32'd0,         32'd0},         1'b0, QUIET},
		'{'{sbq_pkg::CMD_WRITE,   10'd10,   32'hDEAD_BEEF, 32'd0},         1'b0, QUIET},
		'{'{sbq_pkg::CMD_STEP,    10'd0,    32'd0,         32'd0},         1'b0, QUIET},
		'{'{sbq_pkg::CMD_WRITE,   10'd3,    32'd11,        32'd0},         1'b0, QUIET},
		'{'{sbq_pkg::CMD_WRITE,   10'd4,    OPB_INPUT,     32'd0},         1'b0, QUIET},
		'{'{sbq_pkg::CMD_STEP,    10'd0,    32'd0,         32'h8000_0001}, 1'b0, QUIET},
		'{'{sbq_pkg::CMD_WRITE,   10'd6,    32'd11,        32'd0},         1'b0, QUIET},
		'{'{sbq_pkg::CMD_WRITE,   10'd7,    32'd10,        32'd0},         1'b0, QUIET},
		'{'{sbq_pkg::CMD_WRITE,   10'd8,    32'hFFFF_FFFB, 32'd0},         1'b0, QUIET},
		'{'{sbq_pkg::CMD_STEP,    10'd0,    32'd0,         32'd0},         1'b0, QUIET},
		'{'{sbq_pkg::CMD_STEP,    10'd0,    32'd0,         32'd0},         1'b1,
			HALT_PC_NEG},
		'{'{sbq_pkg::CMD_STEP,    10'd0,    32'd0,         32'd0},         1'b1,
			HALT_PC_NEG},
		'{'{sbq_pkg::CMD_RESTART, 10'd0,    32'd0,         32'd0},         1'b1, QUIET},
		'{'{sbq_pkg::CMD_WRITE,   10'd1,    32'd2000,      32'd0},         1'b1, QUIET},
		'{'{sbq_pkg::CMD_STEP,    10'd0,    32'd0,         32'd0},         1'b1,
			HALT_OUT_SRC},
		'{'{sbq_pkg::CMD_RESTART, 10'd0,    32'd0,         32'd0},         1'b1, QUIET}
	};

	// Word counts for the random phases: the reset value, the smallest legal
	// count, a saturating count above the memory size, and a few in between.
	localparam logic [sbq_pkg::CFG_BITS-1:0] PHASE_WORDS [PHASES] = '{
		11'd1024, 11'd3, 11'd48, 11'd2047, 11'd5, 11'd17, 11'd1024, 11'd300
	};

	// Clock, reset and every block input start at a known value.
	logic                         clk               = 1'b0;
	logic                         arst_n            = 1'b0;
	logic                         cfg_valid         = 1'b0;
	logic                         cfg_ready;
	logic [sbq_pkg::CFG_BITS-1:0] memory_words_used = sbq_pkg::CFG_RESET_WORDS;
	logic                         in_valid          = 1'b0;
	logic                         in_stall;
	logic [1:0]                   command           = sbq_pkg::CMD_WRITE;
	logic [9:0]                   word_address      = '0;
	logic signed [31:0]           write_value       = '0;
	logic signed [31:0]           console_input     = '0;
	logic                         out_valid;
	logic                         out_stall         = 1'b0;
	logic signed [31:0]           read_value;
	logic                         output_valid;
	logic signed [31:0]           output_value;
	logic                         input_taken;
	logic                         halted;
	logic [2:0]                   status;
	logic signed [31:0]           next_pc;

	// The testbench's own copy of the core state, updated at each accepted beat.
	logic [31:0]                  model_mem [MEM_DEPTH];
	logic [31:0]                  model_pc     = '0;
	logic                         model_halted = 1'b0;
	logic [2:0]                   model_reason = sbq_pkg::STAT_RUNNING;
	logic [sbq_pkg::CFG_BITS-1:0] model_words  = sbq_pkg::CFG_RESET_WORDS;

	// Results that have been predicted but not yet seen, oldest first.
	cpu_result_t pending_results [$];

	int  fail_count    = 0;
	int  results_seen  = 0;
	int  beats_counted = 0;
	int  cycle_count   = 0;
	int  rx_hold_cycles = 0;
	bit  tx_idle_on    = 1'b1;
	bit  rx_idle_on    = 1'b1;

	subleq_one_instruction_cpu_core i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.memory_words_used (memory_words_used),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.command           (command),
		.word_address      (word_address),
		.write_value       (write_value),
		.console_input     (console_input),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.read_value        (read_value),
		.output_valid      (output_valid),
		.output_value      (output_value),
		.input_taken       (input_taken),
		.halted            (halted),
		.status            (status),
		.next_pc           (next_pc)
	);

	always #5 clk = ~clk;

	// Words the core may address: the configured count, capped at the memory size.
	function automatic logic [31:0] words_in_use();
		return (model_words > MEM_DEPTH) ? 32'(MEM_DEPTH) : 32'(model_words);
	endfunction

	function automatic logic addr_in_use(logic [31:0] w, logic [31:0] lim);
		return !w[31] && (w < lim);
	endfunction

	task automatic stop_core(logic [2:0] why);
		model_halted = 1'b1;
		model_reason = why;
	endtask

	// Applies one command beat to the model state and returns its result beat.
	task automatic predict_beat(input cpu_beat_t beat, output cpu_result_t res);
		logic [31:0] lim, pc, op_a, op_b, op_c, diff;
		res = '0;
		lim = words_in_use();
		case (beat.cmd)
			sbq_pkg::CMD_WRITE: model_mem[beat.addr] = beat.wval;
			sbq_pkg::CMD_READ: res.read_value = model_mem[beat.addr];
			sbq_pkg::CMD_RESTART: begin
				model_pc = '0;
				model_halted = 1'b0;
				model_reason = sbq_pkg::STAT_RUNNING;
			end
			default: begin
				// A step on a halted core leaves everything as it is.
				if (!model_halted) begin
					pc = model_pc;
					if (pc[31] || pc >= lim) begin
						stop_core(sbq_pkg::STAT_PC_RANGE);
					end else if (pc + 32'd2 >= lim) begin
						stop_core(sbq_pkg::STAT_INCOMPLETE);
					end else begin
						op_a = model_mem[pc[9:0]];
						op_b = model_mem[pc[9:0] + 10'd1];
						op_c = model_mem[pc[9:0] + 10'd2];
						if (op_a == OPA_OUTPUT) begin
							if (!addr_in_use(op_b, lim)) begin
								stop_core(sbq_pkg::STAT_OUT_SRC);
							end else begin
								res.output_valid = 1'b1;
								res.output_value = model_mem[op_b[9:0]];
								model_pc = pc + sbq_pkg::PC_STEP;
							end
						end else if (op_b == OPB_INPUT) begin
							if (!addr_in_use(op_a, lim)) begin
								stop_core(sbq_pkg::STAT_IN_DST);
							end else begin
								model_mem[op_a[9:0]] = beat.cin;
								res.input_taken = 1'b1;
								model_pc = pc + sbq_pkg::PC_STEP;
							end
						end else if (!addr_in_use(op_a, lim)) begin
							stop_core(sbq_pkg::STAT_BAD_A);
						end else if (!addr_in_use(op_b, lim)) begin
							stop_core(sbq_pkg::STAT_BAD_B);
						end else begin
							diff = model_mem[op_a[9:0]] - model_mem[op_b[9:0]];
							model_mem[op_a[9:0]] = diff;
							model_pc = (diff == '0 || diff[31]) ? op_c
								: pc + sbq_pkg::PC_STEP;
						end
					end
				end
			end
		endcase
		res.halted  = model_halted;
		res.status  = model_reason;
		res.next_pc = model_pc;
	endtask

	// A beat with every payload field random, for the given command.
	function automatic cpu_beat_t random_beat(logic [1:0] cmd);
		cpu_beat_t beat;
		beat.cmd  = cmd;
		beat.addr = 10'($urandom);
		beat.wval = $urandom;
		beat.cin  = $urandom;
		return beat;
	endfunction

	// Operand addresses are mostly inside the words in use; the rest land just
	// past the end, on a negative value, or anywhere at all.
	function automatic logic [31:0] pick_operand(logic [31:0] lim);
		case ($urandom_range(0, 15))
			0: return lim;
			1: return {1'b1, 31'($urandom)};
			2: return $urandom;
			default: return 32'($urandom_range(0, lim - 1));
		endcase
	endfunction

	// Offers one command beat and returns right after the edge that accepts it.
	// The sender starts from just after an edge, so its first falling edge is
	// the place to either drop valid for a gap or present the new beat. The
	// expectation for the beat is recorded at acceptance, when the model state
	// is exactly what the core sees.
	task automatic push_beat(input cpu_beat_t beat, input logic typed,
			input cpu_result_t want);
		int gap;
		cpu_result_t predicted;
		gap = tx_idle_on ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		command       <= beat.cmd;
		word_address  <= beat.addr;
		write_value   <= beat.wval;
		console_input <= beat.cin;
		do @(posedge clk); while (in_stall);
		predict_beat(beat, predicted);
		if (typed)
			predicted = want;
		pending_results.insert(pending_results.size(), predicted);
		beats_counted++;
	endtask

	// Stops offering beats and waits until every predicted result has arrived.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes the word count through the configuration channel.
	task automatic set_word_count(logic [sbq_pkg::CFG_BITS-1:0] words);
		@(negedge clk);
		cfg_valid         <= 1'b1;
		memory_words_used <= words;
		do @(posedge clk); while (!cfg_ready);
		model_words = words;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] result %0d: %s is %h, expected %h",
			$realtime, results_seen, what, got, want);
		fail_count++;
	endtask

	// Stimulus: reset, the directed table, then the random phases.
	initial begin : stimulus
		logic [31:0] lim, op_a, op_b, op_c, val;
		int n_instr, n_data, n_steps, pick;
		cpu_beat_t beat;

		foreach (model_mem[i])
			model_mem[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The core sweeps its memory after reset and stalls the input meanwhile,
		// so the first beat simply waits for the stall to drop.
		for (int i = 0; i < DIRECTED_ROWS; i++)
			push_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			// The word count only changes with nothing in flight.
			drain_results();
			set_word_count(PHASE_WORDS[ph]);
			// In two phases the receiver holds off for a long stretch while beats
			// keep coming, so the result register fills and the input stalls.
			if (ph == 2 || ph == 6)
				rx_hold_cycles = LONG_HOLD;
			beats_counted = 0;
			while (beats_counted < BEATS_PER_PHASE) begin
				lim = words_in_use();
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);

				// Load a short program at address 0, one instruction per three
				// words. Most are well formed with mostly valid operands; one in
				// ten is random words.
				n_instr = $urandom_range(1, 8);
				for (int k = 0; k < n_instr; k++) begin
					pick = $urandom_range(0, 9);
					case ($urandom_range(0, 7))
						0: op_c = -32'($urandom_range(1, 8));
						1: op_c = lim + 32'($urandom_range(0, 3));
						2, 3: op_c = 32'($urandom_range(0, lim - 1));
						default: op_c = 32'(3 * $urandom_range(0, n_instr));
					endcase
					if (pick < 2) begin
						op_a = OPA_OUTPUT;
						op_b = pick_operand(lim);
					end else if (pick < 4) begin
						op_a = pick_operand(lim);
						op_b = OPB_INPUT;
					end else if (pick < 9) begin
						op_a = pick_operand(lim);
						op_b = pick_operand(lim);
					end else begin
						op_a = $urandom;
						op_b = $urandom;
						op_c = $urandom;
					end
					beat = random_beat(sbq_pkg::CMD_WRITE);
					beat.addr = 10'(3 * k);
					beat.wval = op_a;
					push_beat(beat, 1'b0, QUIET);
					beat.addr = 10'(3 * k + 1);
					beat.wval = op_b;
					push_beat(beat, 1'b0, QUIET);
					beat.addr = 10'(3 * k + 2);
					beat.wval = op_c;
					push_beat(beat, 1'b0, QUIET);
				end

				// Data words inside the words in use: small values around zero so
				// that subtracts branch both ways, and full-range values.
				n_data = $urandom_range(0, 6);
				for (int k = 0; k < n_data; k++) begin
					val = $urandom_range(0, 1) ? 32'($urandom_range(0, 40)) - 32'd20
						: 32'($urandom);
					beat = random_beat(sbq_pkg::CMD_WRITE);
					beat.addr = 10'($urandom_range(0, lim - 1));
					beat.wval = val;
					push_beat(beat, 1'b0, QUIET);
				end

				push_beat(random_beat(sbq_pkg::CMD_RESTART), 1'b0, QUIET);

				// Run it: mostly steps, with stray reads and writes anywhere in the
				// memory, and a restart most of the time once the core has halted.
				n_steps = $urandom_range(4, 30);
				for (int k = 0; k < n_steps; k++) begin
					pick = $urandom_range(0, 19);
					if (model_halted && pick < 12)
						beat = random_beat(sbq_pkg::CMD_RESTART);
					else if (pick == 0)
						beat = random_beat(sbq_pkg::CMD_READ);
					else if (pick == 1)
						beat = random_beat(sbq_pkg::CMD_WRITE);
					else
						beat = random_beat(sbq_pkg::CMD_STEP);
					push_beat(beat, 1'b0, QUIET);
				end
			end
		end

		// Let any stray result show up before the verdict.
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS subleq_one_instruction_cpu_core");
		else
			$display("FAIL subleq_one_instruction_cpu_core");
		$finish;
	end

	// Result sink: for every result beat it draws a number of stall cycles,
	// raises out_stall for that long, then lowers it until a beat is taken.
	// A long hold requested by the stimulus replaces one draw.
	initial begin : result_sink
		int wait_cycles;
		forever begin
			wait_cycles = rx_idle_on ? $urandom_range(0, 3) : 0;
			if (rx_hold_cycles != 0) begin
				wait_cycles = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			@(negedge clk);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Every accepted result beat is checked against the oldest expectation.
	always @(posedge clk) begin : result_check
		cpu_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{read_value, output_valid, output_value, input_taken,
				halted, status, next_pc};
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, next_pc", got.next_pc, '0);
			end else begin
				want = pending_results.pop_front();
				if (got.read_value !== want.read_value)
					report_mismatch("read_value", got.read_value, want.read_value);
				if (got.output_valid !== want.output_valid)
					report_mismatch("output_valid", 32'(got.output_valid),
						32'(want.output_valid));
				if (got.output_value !== want.output_value)
					report_mismatch("output_value", got.output_value, want.output_value);
				if (got.input_taken !== want.input_taken)
					report_mismatch("input_taken", 32'(got.input_taken),
						32'(want.input_taken));
				if (got.halted !== want.halted)
					report_mismatch("halted", 32'(got.halted), 32'(want.halted));
				if (got.status !== want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.next_pc !== want.next_pc)
					report_mismatch("next_pc", got.next_pc, want.next_pc);
			end
			results_seen++;
		end
	end

	// Watchdog: the slowest correct run is far below this many cycles.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[%0t] timeout with %0d results pending",
				$realtime, pending_results.size());
			$display("FAIL subleq_one_instruction_cpu_core");
			$finish;
		end
	end

endmodule
